// ===== src/ddhc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddhc_pkg
// Shared constants, CORDIC angle table and pipeline side-band types for the
// differential-drive heading controller.
// ----------------------------------------------------------------------------
package ddhc_pkg;

  localparam int POSITION_WIDTH_DEF = 32;

  // register indexes of the configuration port
  localparam logic [2:0] REG_STEER_GAIN        = 3'd0;
  localparam logic [2:0] REG_MAX_TURN_RATE     = 3'd1;
  localparam logic [2:0] REG_MAX_FORWARD_SPEED = 3'd2;
  localparam logic [2:0] REG_ARRIVAL_TOLERANCE = 3'd3;
  localparam logic [2:0] REG_TRACK_WIDTH       = 3'd4;
  localparam logic [2:0] REG_WHEEL_RAD         = 3'd5;
  localparam logic [2:0] REG_MAX_WHEEL_SPEED   = 3'd6;

  localparam int CORDIC_STEPS = 17;
  localparam int VX_W = 61;   // vectoring x/y datapath
  localparam int VZ_W = 19;   // angle accumulator, units of 2^-16 rad
  localparam int RX_W = 27;   // rotation x/y datapath
  localparam int NORM_MSB = 57;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic signed [19:0] PI_Q16 = 20'sd205887;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
  localparam logic [24:0] DIST_CAP = 25'd16777216;

  // atan(2^-i) in units of 2^-16 rad
  localparam logic signed [VZ_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    19'sd51472, 19'sd30386, 19'sd16055, 19'sd8150, 19'sd4091, 19'sd2047,
    19'sd1024, 19'sd512, 19'sd256, 19'sd128, 19'sd64, 19'sd32, 19'sd16,
    19'sd8, 19'sd4, 19'sd2, 19'sd1
  };

  // side band that travels with the vectoring CORDIC
  typedef struct packed {
    logic               same;
    logic               dx_neg;
    logic               dy_neg;
    logic signed [15:0] hd;
    logic [5:0]         s;
  } vec_side_t;

  // side band that travels with the rotation CORDIC
  typedef struct packed {
    logic               reached;
    logic               gate_zero;
    logic signed [15:0] w;
    logic [24:0]        lin;
  } rot_side_t;

endpackage

// ===== src/ddhc_div.sv =====
// ----------------------------------------------------------------------------
// ddhc_div
// Pipelined restoring divider, one quotient bit per stage, with a tag and a
// valid bit carried alongside. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module ddhc_div import ddhc_pkg::*; #(
  parameter int NW = 42,
  parameter int DW = 25,
  parameter int QW = 41,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  localparam int RW = DW + 1;

  logic [RW-1:0] rem  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic [DW-1:0] dd   [0:QW];
  logic [TW-1:0] tg   [0:QW];
  logic          vld  [0:QW];

  // stage zero takes the upper numerator bits as the partial remainder
  assign rem[0] = RW'(num >> QW);
  assign low[0] = num[QW-1:0];
  assign q[0]   = '0;
  assign dd[0]  = den;
  assign tg[0]  = tag_in;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW:0] trial;
    logic        fits;

    assign trial = {rem[k], low[k][QW-1]};
    assign fits  = trial >= {2'b00, dd[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    // compare and subtract, shift one quotient bit in
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? RW'(trial - {2'b00, dd[k]}) : RW'(trial);
        low[k+1] <= low[k] << 1;
        q[k+1]   <= {q[k][QW-2:0], fits};
        dd[k+1]  <= dd[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign tag_out   = tg[QW];

endmodule

// ===== src/diff_drive_heading_controller.sv =====
// ----------------------------------------------------------------------------
// diff_drive_heading_controller
// Go-to-goal controller for a differential-drive rover: pose and target in,
// two wheel speed commands and a reached flag out.
// ----------------------------------------------------------------------------
// While results are taken, one item enters and one result leaves per clock; the
// path runs through the two 17-step CORDIC pipelines (bearing/magnitude and
// cosine gate) and the two bit-per-stage dividers (41 stages for the wheel
// speeds, 15 stages for the common limit scaling). The whole pipeline holds
// while a finished result is not taken. Configuration registers are always
// ready and should only be written while no item is in flight.
module diff_drive_heading_controller import ddhc_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [POSITION_WIDTH-1:0] rover_north,
  input  logic signed [POSITION_WIDTH-1:0] rover_east,
  input  logic signed [15:0]               rover_heading,
  input  logic signed [POSITION_WIDTH-1:0] target_north,
  input  logic signed [POSITION_WIDTH-1:0] target_east,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               left_wheel,
  output logic signed [15:0]               right_wheel,
  output logic                             reached,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [23:0]                      cfg_data
);

  localparam int DW = POSITION_WIDTH + 1;

  logic        adv;
  logic [15:0] steer_gain;
  logic [14:0] max_turn_rate;
  logic [23:0] max_forward_speed;
  logic [23:0] arrival_tolerance;
  logic [23:0] track_width;
  logic [23:0] wheel_rad;
  logic [14:0] max_wheel_speed;

  // pipeline moves unless a result waits at the output
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain        <= 16'd8192;
      max_turn_rate     <= 15'd512;
      max_forward_speed <= 24'd65536;
      arrival_tolerance <= 24'd6554;
      track_width       <= 24'd32768;
      wheel_rad         <= 24'd6554;
      max_wheel_speed   <= 15'd2560;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEER_GAIN:        steer_gain        <= cfg_data[15:0];
        REG_MAX_TURN_RATE:     max_turn_rate     <= cfg_data[14:0];
        REG_MAX_FORWARD_SPEED: max_forward_speed <= cfg_data;
        REG_ARRIVAL_TOLERANCE: arrival_tolerance <= cfg_data;
        REG_TRACK_WIDTH:       track_width       <= cfg_data;
        REG_WHEEL_RAD:         wheel_rad         <= cfg_data;
        REG_MAX_WHEEL_SPEED:   max_wheel_speed   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: position differences ----------------
  logic                 s1_valid;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic signed [15:0]   s1_hd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= DW'(target_east) - DW'(rover_east);
      s1_dy <= DW'(target_north) - DW'(rover_north);
      s1_hd <= rover_heading;
    end
  end

  // ---------------- stage 2: magnitudes ----------------
  logic          s2_valid, s2_same, s2_dx_neg, s2_dy_neg;
  logic [DW-1:0] s2_ax, s2_ay, s2_m;
  logic signed [15:0] s2_hd;
  logic [DW-1:0] ax_c, ay_c;

  assign ax_c = s1_dx[DW-1] ? $unsigned(-s1_dx) : $unsigned(s1_dx);
  assign ay_c = s1_dy[DW-1] ? $unsigned(-s1_dy) : $unsigned(s1_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ax     <= ax_c;
      s2_ay     <= ay_c;
      s2_m      <= (ax_c > ay_c) ? ax_c : ay_c;
      s2_same   <= (s1_dx == '0) && (s1_dy == '0);
      s2_dx_neg <= s1_dx[DW-1];
      s2_dy_neg <= s1_dy[DW-1];
      s2_hd     <= s1_hd;
    end
  end

  // ---------------- stage 3: leading one, normalize shift ----------------
  logic          s3_valid;
  logic [DW-1:0] s3_ax, s3_ay;
  vec_side_t     s3_side;
  logic [5:0]    msb;

  always_comb begin
    msb = '0;
    for (int k = 0; k < DW; k++) begin
      if (s2_m[k]) begin
        msb = 6'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ax          <= s2_ax;
      s3_ay          <= s2_ay;
      s3_side.same   <= s2_same;
      s3_side.dx_neg <= s2_dx_neg;
      s3_side.dy_neg <= s2_dy_neg;
      s3_side.hd     <= s2_hd;
      s3_side.s      <= 6'(NORM_MSB) - msb;
    end
  end

  // ---------------- vectoring CORDIC: bearing and magnitude ----------------
  logic signed [VX_W-1:0] vx [0:CORDIC_STEPS];
  logic signed [VX_W-1:0] vy [0:CORDIC_STEPS];
  logic signed [VZ_W-1:0] vz [0:CORDIC_STEPS];
  vec_side_t              vside [0:CORDIC_STEPS];
  logic                   vvalid [0:CORDIC_STEPS];

  // stage 4 loads the normalized vector
  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid[0] <= 1'b0;
    end else if (adv) begin
      vvalid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx[0]    <= $signed(VX_W'(s3_ax) << s3_side.s);
      vy[0]    <= $signed(VX_W'(s3_ay) << s3_side.s);
      vz[0]    <= '0;
      vside[0] <= s3_side;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vvalid[i+1] <= 1'b0;
      end else if (adv) begin
        vvalid[i+1] <= vvalid[i];
      end
    end

    // drive y toward zero
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ATAN_TAB[i];
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ATAN_TAB[i];
        end
        vside[i+1] <= vside[i];
      end
    end
  end

  // ---------------- D1: denormalize magnitude, bearing, raw error ----------------
  vec_side_t              vs_end;
  logic [VX_W-1:0]        m8_full;
  logic signed [19:0]     zz, bq16, br;
  logic                   d1_valid, d1_cap, d1_same;
  logic [47:0]            d1_m8;
  logic signed [17:0]     d1_err;

  assign vs_end  = vside[CORDIC_STEPS];
  assign m8_full = $unsigned(vx[CORDIC_STEPS]) >> (vs_end.s - 6'd8);
  assign zz      = 20'(vz[CORDIC_STEPS]);

  // fold to four quadrants, round to Q3.13
  always_comb begin
    if (!vs_end.dx_neg) begin
      bq16 = vs_end.dy_neg ? -zz : zz;
    end else begin
      bq16 = vs_end.dy_neg ? (zz - PI_Q16) : (PI_Q16 - zz);
    end
    br = (bq16 + 20'sd4) >>> 3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else if (adv) begin
      d1_valid <= vvalid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_m8   <= m8_full[47:0];
      d1_cap  <= (vs_end.s < 6'd8) || (m8_full[VX_W-1:48] != '0);
      d1_same <= vs_end.same;
      d1_err  <= 18'(br) - 18'(vs_end.hd);
    end
  end

  // ---------------- D2: distance product, error wrap ----------------
  logic               d2_valid, d2_cap, d2_same;
  logic [63:0]        d2_prod;
  logic signed [15:0] d2_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_valid <= 1'b0;
    end else if (adv) begin
      d2_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_prod <= d1_m8 * INV_GAIN_Q16;
      d2_cap  <= d1_cap;
      d2_same <= d1_same;
      if (d1_err >= PI_Q13) begin
        d2_err <= 16'(d1_err - TWO_PI_Q13);
      end else if (d1_err < -PI_Q13) begin
        d2_err <= 16'(d1_err + TWO_PI_Q13);
      end else begin
        d2_err <= 16'(d1_err);
      end
    end
  end

  // ---------------- D3: distance, arrival test, turn product ----------------
  logic [39:0]        dist_rnd;
  logic [24:0]        dist_c, lin_c;
  logic [15:0]        err_abs;
  logic               d3_valid, d3_reached, d3_gz;
  logic [24:0]        d3_lin;
  logic signed [32:0] d3_wprod;
  logic signed [VZ_W-1:0] d3_z0;

  assign dist_rnd = 40'((d2_prod + 64'd8388608) >> 24);
  assign dist_c   = d2_cap ? DIST_CAP :
                    ((dist_rnd > 40'(DIST_CAP)) ? DIST_CAP : 25'(dist_rnd));
  assign lin_c    = (dist_c < {1'b0, max_forward_speed}) ? dist_c
                                                         : {1'b0, max_forward_speed};
  assign err_abs  = d2_err[15] ? $unsigned(-d2_err) : $unsigned(d2_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_valid <= 1'b0;
    end else if (adv) begin
      d3_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_reached <= d2_same || (dist_c <= {1'b0, arrival_tolerance});
      d3_lin     <= lin_c;
      d3_wprod   <= $signed({1'b0, steer_gain}) * d2_err;
      d3_z0      <= $signed({err_abs, 3'b000});
      d3_gz      <= err_abs >= HALF_PI_Q13;
    end
  end

  // ---------------- D4: turn rate clamp, rotation CORDIC load ----------------
  logic signed [RX_W-1:0] rx [0:CORDIC_STEPS];
  logic signed [RX_W-1:0] ry [0:CORDIC_STEPS];
  logic signed [VZ_W-1:0] rz [0:CORDIC_STEPS];
  rot_side_t              rside [0:CORDIC_STEPS];
  logic                   rvalid [0:CORDIC_STEPS];
  logic signed [32:0]     w_full, mtr;
  logic signed [15:0]     w_c;

  assign w_full = (d3_wprod + 33'sd65536) >>> 17;
  assign mtr    = $signed({18'd0, max_turn_rate});

  always_comb begin
    if (w_full > mtr) begin
      w_c = 16'(mtr);
    end else if (w_full < -mtr) begin
      w_c = 16'(-mtr);
    end else begin
      w_c = 16'(w_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid[0] <= 1'b0;
    end else if (adv) begin
      rvalid[0] <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0]              <= $signed(RX_W'({INV_GAIN_Q16, 8'd0}));
      ry[0]              <= '0;
      rz[0]              <= d3_z0;
      rside[0].reached   <= d3_reached;
      rside[0].gate_zero <= d3_gz;
      rside[0].w         <= w_c;
      rside[0].lin       <= d3_lin;
    end
  end

  // ---------------- rotation CORDIC: cosine gate ----------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rvalid[i+1] <= 1'b0;
      end else if (adv) begin
        rvalid[i+1] <= rvalid[i];
      end
    end

    // drive the residual angle toward zero
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rz[i] >= 0) begin
          rx[i+1] <= rx[i] - (ry[i] >>> i);
          ry[i+1] <= ry[i] + (rx[i] >>> i);
          rz[i+1] <= rz[i] - ATAN_TAB[i];
        end else begin
          rx[i+1] <= rx[i] + (ry[i] >>> i);
          ry[i+1] <= ry[i] - (rx[i] >>> i);
          rz[i+1] <= rz[i] + ATAN_TAB[i];
        end
        rside[i+1] <= rside[i];
      end
    end
  end

  // ---------------- G: gate rounding and clamp ----------------
  logic signed [RX_W-1:0] gx;
  logic [16:0]            gate_c;
  logic                   g_valid;
  logic [16:0]            g_gate;
  rot_side_t              g_side;

  assign gx = (rx[CORDIC_STEPS] + 27'sd128) >>> 8;

  always_comb begin
    if (rside[CORDIC_STEPS].gate_zero || gx < 0) begin
      gate_c = '0;
    end else if (gx > 27'sd65536) begin
      gate_c = 17'd65536;
    end else begin
      gate_c = 17'(gx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= rvalid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_gate <= gate_c;
      g_side <= rside[CORDIC_STEPS];
    end
  end

  // ---------------- H: speed and turn products ----------------
  logic               h_valid, h_reached;
  logic [41:0]        h_vprod;
  logic signed [40:0] h_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_vprod   <= g_side.lin * g_gate;
      h_turn    <= g_side.w * $signed({1'b0, track_width});
      h_reached <= g_side.reached;
    end
  end

  // ---------------- I: wheel numerators ----------------
  logic [25:0]        v_c;
  logic signed [41:0] pv;
  logic               i_valid, i_reached;
  logic signed [41:0] i_nl, i_nr;

  assign v_c = 26'((h_vprod + 42'd32768) >> 16);
  assign pv  = $signed({7'd0, v_c, 9'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (adv) begin
      i_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_nl      <= pv - 42'(h_turn);
      i_nr      <= pv + 42'(h_turn);
      i_reached <= h_reached;
    end
  end

  // ---------------- I2: rounding numerators for the wheel division ----------------
  logic [41:0] al_c, ar_c;
  logic [23:0] rad_c;
  logic        i2_valid, i2_reached, i2_l_neg, i2_r_neg;
  logic [41:0] i2_numl, i2_numr;
  logic [24:0] i2_den;

  assign al_c  = i_nl[41] ? $unsigned(-i_nl) : $unsigned(i_nl);
  assign ar_c  = i_nr[41] ? $unsigned(-i_nr) : $unsigned(i_nr);
  assign rad_c = (wheel_rad == '0) ? 24'd1 : wheel_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      i2_valid <= 1'b0;
    end else if (adv) begin
      i2_valid <= i_valid;
    end
  end

  // |n| / (2 * radius), halves away from zero: (|n| + radius) / (2 * radius)
  always_ff @(posedge clk) begin
    if (adv) begin
      i2_numl    <= al_c + 42'(rad_c);
      i2_numr    <= ar_c + 42'(rad_c);
      i2_den     <= {rad_c, 1'b0};
      i2_l_neg   <= i_nl[41];
      i2_r_neg   <= i_nr[41];
      i2_reached <= i_reached;
    end
  end

  // ---------------- wheel speed dividers ----------------
  logic        da_lv, da_rv;
  logic [40:0] qa_l, qa_r;
  logic [1:0]  da_ltag;
  logic [0:0]  da_rtag;

  ddhc_div #(.NW(42), .DW(25), .QW(41), .TW(2)) u_div_al (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (i2_valid),
    .num      (i2_numl),
    .den      (i2_den),
    .tag_in   ({i2_reached, i2_l_neg}),
    .out_valid(da_lv),
    .quo      (qa_l),
    .tag_out  (da_ltag)
  );

  ddhc_div #(.NW(42), .DW(25), .QW(41), .TW(1)) u_div_ar (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (i2_valid),
    .num      (i2_numr),
    .den      (i2_den),
    .tag_in   (i2_r_neg),
    .out_valid(da_rv),
    .quo      (qa_r),
    .tag_out  (da_rtag)
  );

  // ---------------- J: largest magnitude, scaling products ----------------
  logic [40:0]        big_c;
  logic               j_valid, j_reached, j_sel, j_l_neg, j_r_neg;
  logic [40:0]        j_big;
  logic [55:0]        j_pl, j_pr;
  logic signed [15:0] j_lw, j_rw;

  assign big_c = (qa_l > qa_r) ? qa_l : qa_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (adv) begin
      j_valid <= da_lv && da_rv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_big     <= big_c;
      j_sel     <= big_c > 41'(max_wheel_speed);
      j_pl      <= qa_l * max_wheel_speed;
      j_pr      <= qa_r * max_wheel_speed;
      j_lw      <= da_ltag[0] ? -$signed(qa_l[15:0]) : $signed(qa_l[15:0]);
      j_rw      <= da_rtag[0] ? -$signed(qa_r[15:0]) : $signed(qa_r[15:0]);
      j_l_neg   <= da_ltag[0];
      j_r_neg   <= da_rtag[0];
      j_reached <= da_ltag[1];
    end
  end

  // ---------------- K: rounding numerators for the limit scaling ----------------
  logic        k_valid;
  logic [57:0] k_numl, k_numr;
  logic [41:0] k_den;
  logic [18:0] k_ltag;
  logic [16:0] k_rtag;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_valid <= 1'b0;
    end else if (adv) begin
      k_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_numl <= {1'b0, j_pl, 1'b0} + 58'(j_big);
      k_numr <= {1'b0, j_pr, 1'b0} + 58'(j_big);
      k_den  <= {j_big, 1'b0};
      k_ltag <= {j_reached, j_sel, j_l_neg, j_lw};
      k_rtag <= {j_r_neg, j_rw};
    end
  end

  // ---------------- limit scaling dividers ----------------
  logic        db_lv, db_rv;
  logic [14:0] qb_l, qb_r;
  logic [18:0] db_ltag;
  logic [16:0] db_rtag;

  ddhc_div #(.NW(58), .DW(42), .QW(15), .TW(19)) u_div_bl (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (k_valid),
    .num      (k_numl),
    .den      (k_den),
    .tag_in   (k_ltag),
    .out_valid(db_lv),
    .quo      (qb_l),
    .tag_out  (db_ltag)
  );

  ddhc_div #(.NW(58), .DW(42), .QW(15), .TW(17)) u_div_br (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (k_valid),
    .num      (k_numr),
    .den      (k_den),
    .tag_in   (k_rtag),
    .out_valid(db_rv),
    .quo      (qb_r),
    .tag_out  (db_rtag)
  );

  // ---------------- L: output register ----------------
  logic               o_reached, o_sel, o_l_neg, o_r_neg;
  logic signed [15:0] o_lw, o_rw, sl, sr;

  assign {o_reached, o_sel, o_l_neg, o_lw} = db_ltag;
  assign {o_r_neg, o_rw}                   = db_rtag;
  assign sl = o_l_neg ? -$signed({1'b0, qb_l}) : $signed({1'b0, qb_l});
  assign sr = o_r_neg ? -$signed({1'b0, qb_r}) : $signed({1'b0, qb_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= db_lv && db_rv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reached <= o_reached;
      if (o_reached) begin
        left_wheel  <= '0;
        right_wheel <= '0;
      end else if (o_sel) begin
        left_wheel  <= sl;
        right_wheel <= sr;
      end else begin
        left_wheel  <= o_lw;
        right_wheel <= o_rw;
      end
    end
  end

endmodule

// ===== dv/ddhc_checker.sv =====
// ----------------------------------------------------------------------------
// ddhc_checker
// Watches the pose, wheel command and register channels of the heading
// controller, predicts each wheel command from the accepted pose and the
// current register values, and compares the results in order.
// ----------------------------------------------------------------------------
module ddhc_checker import ddhc_pkg::*; #(
  parameter int PW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [PW-1:0] rover_north,
  input  logic signed [PW-1:0] rover_east,
  input  logic signed [15:0]   rover_heading,
  input  logic signed [PW-1:0] target_north,
  input  logic signed [PW-1:0] target_east,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [15:0]   left_wheel,
  input  logic signed [15:0]   right_wheel,
  input  logic                 reached,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               reached;
  } wheel_cmd_t;

  localparam longint ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  wheel_cmd_t expected_cmds[$];

  // local copy of the register file
  longint gain, turn_lim, fwd_lim, tol, track, radius, wheel_lim;

  // divide rounded to nearest, halves away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    bit [63:0] an;
    bit [63:0] q;
    an = (num < 0) ? -num : num;
    q = (2 * an + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wheel_cmd_t predict_wheels(longint rn, longint re, longint hd,
                                                longint tn, longint te);
    wheel_cmd_t r;
    longint dx, dy, x, y, z, xs, ys, bearing, err, w, gate, lw, rw, rad, big;
    longint v, turn;
    bit [63:0] ax, ay, m, m8, dist_q, lin;
    int s;
    r.left = '0;
    r.right = '0;
    r.reached = 1'b1;
    dy = tn - rn;
    dx = te - re;
    if (dx == 0 && dy == 0) return r;

    // vectoring pass on the normalized absolute offsets
    ax = mag(dx);
    ay = mag(dy);
    m = (ax > ay) ? ax : ay;
    s = 0;
    while (m < (64'd1 << 57)) begin
      m = m << 1;
      s++;
    end
    x = ax << s;
    y = ay << s;
    z = 0;
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_Q16[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q16[i];
      end
    end
    if (s < 8) begin
      dist_q = 64'd16777216;
    end else begin
      m8 = 64'(x) >> (s - 8);
      if (m8 >= (64'd1 << 48)) dist_q = 64'd16777216;
      else dist_q = (m8 * 64'd39797 + (64'd1 << 23)) >> 24;
      if (dist_q > 64'd16777216) dist_q = 64'd16777216;
    end
    if (dist_q <= tol) return r;
    r.reached = 1'b0;

    // quadrant fold and heading error wrap
    if (dx >= 0) bearing = (dy >= 0) ? z : -z;
    else bearing = (dy >= 0) ? (205887 - z) : (z - 205887);
    bearing = (bearing + 4) >>> 3;
    err = bearing - hd;
    while (err >= 25736) err -= 51472;
    while (err < -25736) err += 51472;

    w = (gain * err + 65536) >>> 17;
    if (w > turn_lim) w = turn_lim;
    if (w < -turn_lim) w = -turn_lim;

    // cosine gate by rotation
    if (mag(err) >= 12868) begin
      gate = 0;
    end else begin
      x = 39797 << 8;
      y = 0;
      z = mag(err) * 8;
      for (int i = 0; i < 17; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= ATAN_Q16[i];
        end else begin
          x += ys; y -= xs; z += ATAN_Q16[i];
        end
      end
      gate = (x + 128) >>> 8;
      if (gate < 0) gate = 0;
      if (gate > 65536) gate = 65536;
    end

    // inverse kinematics and common scaling
    lin = (dist_q < fwd_lim) ? dist_q : fwd_lim;
    v = longint'((lin * 64'(gate) + 64'd32768) >> 16);
    turn = w * track;
    rad = (radius == 0) ? 1 : radius;
    lw = round_div(512 * v - turn, 2 * rad);
    rw = round_div(512 * v + turn, 2 * rad);
    big = (mag(lw) > mag(rw)) ? mag(lw) : mag(rw);
    if (big > wheel_lim) begin
      lw = round_div(lw * wheel_lim, big);
      rw = round_div(rw * wheel_lim, big);
      if (lw > wheel_lim) lw = wheel_lim;
      if (lw < -wheel_lim) lw = -wheel_lim;
      if (rw > wheel_lim) rw = wheel_lim;
      if (rw < -wheel_lim) rw = -wheel_lim;
    end
    r.left = lw[15:0];
    r.right = rw[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // handshakes are sampled mid-cycle, all inputs being stable then
  always @(negedge clk) begin
    wheel_cmd_t want;
    if (rst) begin
      expected_cmds.delete();
      gain = 8192; turn_lim = 512; fwd_lim = 65536; tol = 6554;
      track = 32768; radius = 6554; wheel_lim = 2560;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEER_GAIN:        gain = cfg_data[15:0];
          REG_MAX_TURN_RATE:     turn_lim = cfg_data[14:0];
          REG_MAX_FORWARD_SPEED: fwd_lim = cfg_data;
          REG_ARRIVAL_TOLERANCE: tol = cfg_data;
          REG_TRACK_WIDTH:       track = cfg_data;
          REG_WHEEL_RAD:         radius = cfg_data;
          REG_MAX_WHEEL_SPEED:   wheel_lim = cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (left_wheel !== want.left) report_mismatch("left_wheel", left_wheel, want.left);
          if (right_wheel !== want.right)
            report_mismatch("right_wheel", right_wheel, want.right);
          if (reached !== want.reached) report_mismatch("reached", reached, want.reached);
        end
      end
      if (in_valid && in_ready)
        expected_cmds.push_back(predict_wheels(rover_north, rover_east, rover_heading,
                                               target_north, target_east));
    end
    pending = expected_cmds.size();
  end

  initial errors = 0;

endmodule

// ===== dv/tb_diff_drive_heading_controller.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_heading_controller
// Drives poses and register settings into the heading controller with random
// bursts and output stalls; the checker predicts and compares every command.
// ----------------------------------------------------------------------------
module tb_diff_drive_heading_controller import ddhc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = 32;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [PW-1:0] rover_north;
  logic signed [PW-1:0] rover_east;
  logic signed [15:0]   rover_heading;
  logic signed [PW-1:0] target_north;
  logic signed [PW-1:0] target_east;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [15:0]   left_wheel;
  logic signed [15:0]   right_wheel;
  logic                 reached;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [2:0]           cfg_index;
  logic [23:0]          cfg_data;
  int                   errors;
  int                   pending;
  int                   hold_req;
  int                   burst_left;

  diff_drive_heading_controller #(.POSITION_WIDTH(PW)) dut (.*);

  ddhc_checker #(.PW(PW)) checker_i (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stalls: a mode per window, plus one long hold-off on request
  initial begin
    int hold_done;
    int mode;
    hold_done = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        repeat (48) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // hands one pose item over; called at a rising edge, returns at the accepting one
  task automatic send_pose(logic [PW-1:0] rn, logic [PW-1:0] re, logic [15:0] hd,
                           logic [PW-1:0] tn, logic [PW-1:0] te);
    bit ok;
    in_valid <= 1'b1;
    rover_north <= rn;
    rover_east <= re;
    rover_heading <= hd;
    target_north <= tn;
    target_east <= te;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // random pose item, sender idles between bursts
  task automatic send_random_pose();
    logic [PW-1:0] rn, re, tn, te, dn, de;
    logic [15:0] hd;
    int shift;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    rn = $urandom;
    re = $urandom;
    shift = $urandom_range(0, 31);
    dn = $signed($urandom) >>> shift;
    de = $signed($urandom) >>> shift;
    case ($urandom_range(0, 9))
      0: begin tn = $urandom; te = $urandom; end
      1: begin tn = rn; te = re; end
      2: begin tn = rn + ($signed($urandom) >>> 19); te = re + ($signed($urandom) >>> 19); end
      default: begin tn = rn + dn; te = re + de; end
    endcase
    if ($urandom_range(0, 4) == 0) hd = 16'($urandom);
    else hd = 16'($signed($urandom_range(0, 51471)) - 25736);
    send_pose(rn, re, hd, tn, te);
  endtask

  // register write; called at a rising edge, returns at the accepting one
  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // stop offering items and let every expected command come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [23:0] vals [7];
    int phase;
    in_valid = 1'b0;
    rover_north = '0;
    rover_east = '0;
    rover_heading = '0;
    target_north = '0;
    target_east = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    burst_left = 0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed poses under the reset settings
    send_pose(0, 0, 0, 0, 0);                                   // same point
    send_pose(32'h1234_5678, 32'h8000_0000, 0, 32'h1234_5678, 32'h8000_0000);
    send_pose(32'h8000_0000, 32'h8000_0000, 16'sd25735, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pose(32'h7fff_ffff, 32'h7fff_ffff, -16'sd25736, 32'h8000_0000, 32'h8000_0000);
    send_pose(0, 0, 16'h7fff, 32'h0001_0000, 0);                // heading out of range
    send_pose(0, 0, 16'h8000, 0, 32'h0001_0000);
    send_pose(0, 0, 0, 0, 32'h0005_0000);                       // straight east
    send_pose(0, 0, 0, 32'h0005_0000, 0);                       // north, error of pi/2
    send_pose(0, 0, 0, 0, -32'sh0005_0000);                     // behind
    send_pose(0, 0, 0, -32'sh0005_0000, 0);
    send_pose(0, 0, 0, 32'h0003_0000, 32'hfffd_0000);           // four quadrants
    send_pose(0, 0, 0, 32'hfffd_0000, 32'hfffd_0000);
    send_pose(0, 0, 0, 32'hfffd_0000, 32'h0003_0000);
    send_pose(0, 0, 0, 32'h0003_0000, 32'h0003_0000);
    send_pose(0, 0, 0, 0, 32'd6554);                            // at tolerance
    send_pose(0, 0, 0, 0, 32'd6560);                            // just past it
    send_pose(0, 0, 16'sd12867, 0, 32'h0010_0000);
    send_pose(0, 0, 16'sd12868, 0, 32'h0010_0000);
    send_pose(0, 0, 16'sd100, 32'h0000_2000, 32'h0100_0000);
    send_pose(32'hffff_ffff, 32'h0, 16'hffff, 32'h0, 32'hffff_ffff);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: vals = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        1: vals = '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                    24'hffffff, 24'hffffff};
        2: vals = '{24'd65535, 24'd32767, 24'd16777215, 24'd0, 24'd1, 24'd1, 24'd1};
        default: begin
          vals[0] = 24'($urandom);
          vals[1] = 24'($urandom_range(0, 2048));
          vals[2] = 24'($urandom_range(0, 1 << 20));
          vals[3] = 24'($urandom_range(0, 1 << 17));
          vals[4] = 24'($urandom_range(1, 1 << 18));
          vals[5] = 24'($urandom_range(1, 1 << 16));
          vals[6] = 24'($urandom_range(1, 32767));
        end
      endcase
      write_reg(REG_STEER_GAIN, vals[0]);
      write_reg(REG_MAX_TURN_RATE, vals[1]);
      write_reg(REG_MAX_FORWARD_SPEED, vals[2]);
      write_reg(REG_ARRIVAL_TOLERANCE, vals[3]);
      write_reg(REG_TRACK_WIDTH, vals[4]);
      write_reg(REG_WHEEL_RAD, vals[5]);
      write_reg(REG_MAX_WHEEL_SPEED, vals[6]);
      write_reg(3'd7, 24'($urandom));                           // unmapped index
      cfg_valid <= 1'b0;
      @(posedge clk);
      // long receiver hold-off while the sender keeps offering
      if (phase == 3) hold_req = 1;
      repeat (130) send_random_pose();
      drain();
    end

    repeat (120) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
